FILE: hw/rtl/als_pkg.sv
// shared types, constants and codes of the adjacency list edge store
package als_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_ARCS     = 256;
  localparam int VTX_W        = 6;
  localparam int HEAD_AW      = 6;
  localparam int NODE_AW      = 8;
  localparam int PTR_W        = 9;
  localparam int WT_W         = 16;
  localparam int CNT_W        = 9;
  localparam int VCNT_W       = 7;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(MAX_ARCS);

  localparam logic [2:0] MODE_INS     = 3'd0;
  localparam logic [2:0] MODE_INS_BI  = 3'd1;
  localparam logic [2:0] MODE_REM     = 3'd2;
  localparam logic [2:0] MODE_REM_BI  = 3'd3;
  localparam logic [2:0] MODE_LOOKUP  = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [VTX_W-1:0] dest;
    logic [WT_W-1:0]  weight;
    logic [PTR_W-1:0] next;
  } node_t;

  typedef struct packed {
    logic               rd_en;
    logic [HEAD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [HEAD_AW-1:0] wr_addr;
    logic [PTR_W-1:0]   wr_data;
    logic               clear;
  } head_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [NODE_AW-1:0] rd_addr;
    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    node_t              wr_data;
  } node_req_t;

endpackage

FILE: hw/rtl/als_in_if.sv
// request channel interface
interface als_in_if;
  import als_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [VTX_W-1:0]  source_vertex;
  logic [VTX_W-1:0]  dest_vertex;
  logic signed [WT_W-1:0] edge_weight;
  modport source (output valid, mode, source_vertex, dest_vertex, edge_weight, input ready);
  modport sink (input valid, mode, source_vertex, dest_vertex, edge_weight, output ready);
endinterface

FILE: hw/rtl/als_out_if.sv
// result channel interface
interface als_out_if;
  import als_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [WT_W-1:0] weight_out;
  logic              source_list_empty;
  logic [CNT_W-1:0]  arc_count;
  modport source (output valid, status, weight_out, source_list_empty, arc_count,
                  input ready);
  modport sink (input valid, status, weight_out, source_list_empty, arc_count,
                output ready);
endinterface

FILE: hw/rtl/als_cfg_if.sv
// configuration write channel interface
interface als_cfg_if;
  import als_pkg::*;
  logic              valid;
  logic              ready;
  logic [VCNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/als_head_ram.sv
// list head memory with per-vertex valid bits, null when not valid
module als_head_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  als_pkg::head_req_t        req,
  output logic [als_pkg::PTR_W-1:0] rd_data
);
  import als_pkg::*;

  logic [PTR_W-1:0]        mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid_r;
  logic [PTR_W-1:0]        q_r;
  logic                    q_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        q_valid_r <= valid_r[req.rd_addr];
      end
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = q_valid_r ? q_r : NULL_PTR;
endmodule

FILE: hw/rtl/als_node_ram.sv
// node pool memory: destination, weight and next pointer per node
module als_node_ram (
  input  logic               clk,
  input  als_pkg::node_req_t req,
  output als_pkg::node_t     rd_data
);
  import als_pkg::*;

  node_t mem [MAX_ARCS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

FILE: hw/rtl/als_ctrl.sv
// request sequencer: allocation, list walk, unlink and result register
module als_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [als_pkg::VCNT_W-1:0]  vertex_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_mode,
  input  logic [als_pkg::VTX_W-1:0]   in_src,
  input  logic [als_pkg::VTX_W-1:0]   in_dst,
  input  logic [als_pkg::WT_W-1:0]    in_wt,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [als_pkg::WT_W-1:0]    out_weight,
  output logic                        out_empty,
  output logic [als_pkg::CNT_W-1:0]   out_count,
  output als_pkg::head_req_t          head_req,
  input  logic [als_pkg::PTR_W-1:0]   head_q,
  output als_pkg::node_req_t          node_req,
  input  als_pkg::node_t              node_q
);
  import als_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_PUSH_RD  = 4'd2;
  localparam logic [3:0] S_PUSH_WR  = 4'd3;
  localparam logic [3:0] S_FIND_RD  = 4'd4;
  localparam logic [3:0] S_FIND_HD  = 4'd5;
  localparam logic [3:0] S_WALK     = 4'd6;
  localparam logic [3:0] S_FREE     = 4'd7;
  localparam logic [3:0] S_EMPTY_RD = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [VTX_W-1:0]   src_r, src_nxt, dst_r, dst_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [WT_W-1:0]    wt_r, wt_nxt, wout_r, wout_nxt;
  logic               second_r, second_nxt;
  logic [PTR_W-1:0]   free_r, free_nxt, fresh_r, fresh_nxt, prev_r, prev_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [NODE_AW-1:0] cur_r, cur_nxt, alloc;
  node_t              curnode_r, curnode_nxt, prevnode_r, prevnode_nxt;
  logic               ov_r, ov_nxt, oe_r, oe_nxt;
  logic [1:0]         os_r, os_nxt;
  logic [WT_W-1:0]    ow_r, ow_nxt;
  logic [CNT_W-1:0]   oc_r, oc_nxt;
  logic               src_ok, dst_ok;

  assign src_ok = {1'b0, src_r} < vertex_count;
  assign dst_ok = {1'b0, dst_r} < vertex_count;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;     src_nxt = src_r;
    dst_nxt = dst_r;       a_nxt = a_r;           b_nxt = b_r;
    wt_nxt = wt_r;         wout_nxt = wout_r;     second_nxt = second_r;
    free_nxt = free_r;     fresh_nxt = fresh_r;   prev_nxt = prev_r;
    count_nxt = count_r;   status_nxt = status_r; cur_nxt = cur_r;
    curnode_nxt = curnode_r; prevnode_nxt = prevnode_r;
    ov_nxt = ov_r;         oe_nxt = oe_r;         os_nxt = os_r;
    ow_nxt = ow_r;         oc_nxt = oc_r;
    head_req = '0;
    node_req = '0;
    alloc = fresh_r[NODE_AW-1:0];
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode; src_nxt = in_src; dst_nxt = in_dst; wt_nxt = in_wt;
          a_nxt = in_src; b_nxt = in_dst;
          status_nxt = ST_OK; wout_nxt = '0; second_nxt = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EMPTY_RD;
        if (mode_r <= MODE_LOOKUP && !(src_ok && dst_ok)) begin
          status_nxt = ST_INVALID;
        end else begin
          case (mode_r) inside
            MODE_INS: begin
              if (count_r >= CNT_W'(MAX_ARCS)) status_nxt = ST_FULL;
              else state_nxt = S_PUSH_RD;
            end
            MODE_INS_BI: begin
              if (count_r > CNT_W'(MAX_ARCS - 2)) status_nxt = ST_FULL;
              else state_nxt = S_PUSH_RD;
            end
            MODE_REM, MODE_REM_BI, MODE_LOOKUP: state_nxt = S_FIND_RD;
            MODE_CLEAR: begin
              head_req.clear = 1'b1;
              free_nxt = NULL_PTR; fresh_nxt = '0; count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_PUSH_RD: begin
        head_req.rd_en = 1'b1; head_req.rd_addr = a_r;
        node_req.rd_en = 1'b1; node_req.rd_addr = free_r[NODE_AW-1:0];
        state_nxt = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        // reuse a freed node first, then hand out never-used ones in order
        if (!free_r[PTR_W-1]) begin
          alloc = free_r[NODE_AW-1:0];
          free_nxt = node_q.next;
        end else begin
          fresh_nxt = fresh_r + PTR_W'(1);
        end
        node_req.wr_en = 1'b1; node_req.wr_addr = alloc;
        node_req.wr_data = '{dest: b_r, weight: wt_r, next: head_q};
        head_req.wr_en = 1'b1; head_req.wr_addr = a_r;
        head_req.wr_data = {1'b0, alloc};
        count_nxt = count_r + CNT_W'(1);
        if (mode_r == MODE_INS_BI && !second_r) begin
          second_nxt = 1'b1; a_nxt = b_r; b_nxt = a_r;
          state_nxt = S_PUSH_RD;
        end else begin
          state_nxt = S_EMPTY_RD;
        end
      end
      S_FIND_RD: begin
        head_req.rd_en = 1'b1; head_req.rd_addr = a_r;
        state_nxt = S_FIND_HD;
      end
      S_FIND_HD: begin
        if (head_q[PTR_W-1]) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt = S_EMPTY_RD;
        end else begin
          node_req.rd_en = 1'b1; node_req.rd_addr = head_q[NODE_AW-1:0];
          cur_nxt = head_q[NODE_AW-1:0]; prev_nxt = NULL_PTR;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (node_q.dest == b_r) begin
          if (mode_r == MODE_LOOKUP) begin
            wout_nxt = node_q.weight;
            state_nxt = S_EMPTY_RD;
          end else begin
            // reverse pass keeps the forward weight
            if (!second_r) wout_nxt = node_q.weight;
            curnode_nxt = node_q;
            if (prev_r[PTR_W-1]) begin
              head_req.wr_en = 1'b1; head_req.wr_addr = a_r;
              head_req.wr_data = node_q.next;
            end else begin
              node_req.wr_en = 1'b1; node_req.wr_addr = prev_r[NODE_AW-1:0];
              node_req.wr_data = '{dest: prevnode_r.dest, weight: prevnode_r.weight,
                                   next: node_q.next};
            end
            state_nxt = S_FREE;
          end
        end else if (node_q.next[PTR_W-1]) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt = S_EMPTY_RD;
        end else begin
          prev_nxt = {1'b0, cur_r}; prevnode_nxt = node_q;
          cur_nxt = node_q.next[NODE_AW-1:0];
          node_req.rd_en = 1'b1; node_req.rd_addr = node_q.next[NODE_AW-1:0];
        end
      end
      S_FREE: begin
        node_req.wr_en = 1'b1; node_req.wr_addr = cur_r;
        node_req.wr_data = '{dest: curnode_r.dest, weight: curnode_r.weight, next: free_r};
        free_nxt = {1'b0, cur_r};
        count_nxt = count_r - CNT_W'(1);
        if (mode_r == MODE_REM_BI && !second_r) begin
          second_nxt = 1'b1; a_nxt = b_r; b_nxt = a_r;
          state_nxt = S_FIND_RD;
        end else begin
          state_nxt = S_EMPTY_RD;
        end
      end
      S_EMPTY_RD: begin
        head_req.rd_en = 1'b1; head_req.rd_addr = src_r;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; os_nxt = status_r; ow_nxt = wout_r;
          oe_nxt = src_ok && head_q[PTR_W-1]; oc_nxt = count_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; free_r <= NULL_PTR; fresh_r <= '0;
      count_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; free_r <= free_nxt; fresh_r <= fresh_nxt;
      count_r <= count_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; src_r <= src_nxt; dst_r <= dst_nxt; a_r <= a_nxt; b_r <= b_nxt;
    wt_r <= wt_nxt; wout_r <= wout_nxt; second_r <= second_nxt; prev_r <= prev_nxt;
    status_r <= status_nxt; cur_r <= cur_nxt; curnode_r <= curnode_nxt;
    prevnode_r <= prevnode_nxt; oe_r <= oe_nxt; os_r <= os_nxt; ow_r <= ow_nxt;
    oc_r <= oc_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_weight = ow_r;
  assign out_empty  = oe_r;
  assign out_count  = oc_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ARCS)) else $error("arc count above pool size");
  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= PTR_W'(MAX_ARCS)) else $error("fresh mark above pool size");
  a_fresh_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fresh_r) else $error("more arcs than nodes ever handed out");
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_FINISH) else $error("result not from finish");
endmodule

FILE: hw/rtl/adjacency_list_edge_store.sv
// adjacency list edge store: top level with configuration register
// Usage: requests arrive on in_if (mode, source_vertex, dest_vertex,
// edge_weight) and each one yields exactly one result on out_if (status,
// weight_out, source_list_empty, arc_count). cfg_if writes vertex_count and
// is always ready; write it only while no request is in flight.
// One request is worked at a time. An insert reads the list head and the
// free list head, then writes the new node in front of the source list,
// and insert both ways does the same again with the vertices swapped.
// Lookup and remove walk the source list from its head; remove unlinks the
// arc found and puts its node on the free list, and remove both ways then
// walks and unlinks the reverse arc. The walk reads one node per cycle from
// the node pool memory, which sets the rate.
// in_if.ready is high whenever the sequencer is idle; a finished result
// sits in the output register, so the next request is taken while the
// receiver stalls, and it waits only at its own result slot.
// Reset (rst_n, synchronous) empties every list through the head valid
// bits and sets vertex_count to 64; no clearing pass is needed.
module adjacency_list_edge_store (
  input logic clk,
  input logic rst_n,
  als_in_if.sink    in_if,
  als_out_if.source out_if,
  als_cfg_if.sink   cfg_if
);
  import als_pkg::*;

  logic [VCNT_W-1:0] vcount_r;
  head_req_t         head_req;
  node_req_t         node_req;
  logic [PTR_W-1:0]  head_q;
  node_t             node_q;
  logic [WT_W-1:0]   wout;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCNT_W'(MAX_VERTICES);
    end else if (cfg_if.valid) begin
      vcount_r <= cfg_if.data;
    end
  end

  als_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .vertex_count(vcount_r),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_mode(in_if.mode),
    .in_src(in_if.source_vertex), .in_dst(in_if.dest_vertex),
    .in_wt(in_if.edge_weight),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_status(out_if.status),
    .out_weight(wout), .out_empty(out_if.source_list_empty),
    .out_count(out_if.arc_count),
    .head_req(head_req), .head_q(head_q), .node_req(node_req), .node_q(node_q)
  );

  assign out_if.weight_out = wout;

  als_head_ram u_head (.clk(clk), .rst_n(rst_n), .req(head_req), .rd_data(head_q));
  als_node_ram u_node (.clk(clk), .req(node_req), .rd_data(node_q));
endmodule
